FILE: rtl/sds_pkg.sv
// Shared types and constants for the fourth-order second-derivative grid stencil.
// No dependencies; imported by every module of the block.
package sds_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int SAMPLE_BITS = 16;
   localparam int LINES       = 4;
   localparam int LANE_BITS   = $clog2(LINES);
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int ROW_BITS    = 16;
   localparam int GW_BITS     = 11;
   localparam int CSR_BITS    = 16;
   localparam int CSR_IDX_BITS = 2;
   localparam int DER_BITS    = 19;
   localparam int QUO_BITS    = DER_BITS - 1;

   // exact stencil sum and the divide-by-12 datapath
   localparam int SUM_BITS    = SAMPLE_BITS + 7;
   localparam int MAG_BITS    = SUM_BITS - 1;
   localparam int QIN_BITS    = MAG_BITS - 2;
   localparam int RECIP_SHIFT = 21;
   localparam int RECIP3      = 699051;          // ceil(2^21 / 3)
   localparam int PROD_BITS   = 2 * QIN_BITS;
   localparam int DER_LIMIT   = 174763;

   localparam int STENCIL_REACH = 4;
   localparam int HALF_REACH    = 2;

   localparam int MID_DEPTH    = 4;
   localparam int MID_PTR_BITS = $clog2(MID_DEPTH);
   localparam int OUT_DEPTH    = 4;
   localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);

   localparam logic [CSR_IDX_BITS-1:0] CSR_DIRECTION   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_HEIGHT = 2'd2;

   typedef enum logic {
      DIR_X = 1'b0,
      DIR_Z = 1'b1
   } dir_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] a;
      logic signed [SAMPLE_BITS-1:0] b;
      logic signed [SAMPLE_BITS-1:0] c;
      logic signed [SAMPLE_BITS-1:0] d;
      logic signed [SAMPLE_BITS-1:0] e;
      logic [ROW_BITS-1:0]           row;
      logic [COL_BITS-1:0]           col;
      logic                          last;
   } op_item_type;

   typedef struct packed {
      logic signed [DER_BITS-1:0] der;
      logic [ROW_BITS-1:0]        row;
      logic [COL_BITS-1:0]        col;
      logic                       last;
   } rsp_item_type;

endpackage

FILE: rtl/sds_front.sv
// Front end: raster position, config registers, x-mode window, line store.
// Emits five stencil operands per interior point; depends on sds_pkg.
module sds_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic signed [sds_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                csr_we,
   input  logic [sds_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [sds_pkg::CSR_BITS-1:0]        csr_wdata,
   output logic                                mid_valid,
   input  logic                                mid_ready,
   output sds_pkg::op_item_type                mid_item
);
   import sds_pkg::*;

   dir_type               dir_ff, dir_in;
   logic [COL_BITS-1:0]   w_last_ff, w_last_in;
   logic [ROW_BITS-1:0]   h_last_ff, h_last_in;
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic                  s1_valid_ff, s1_valid_in;

   logic signed [SAMPLE_BITS-1:0] win_ff [LINES];
   logic signed [SAMPLE_BITS-1:0] rd_ff [LINES];
   logic signed [SAMPLE_BITS-1:0] line_mem [LINES][MAX_WIDTH];

   dir_type                       s1_dir_ff;
   logic [LANE_BITS-1:0]          s1_lane_ff;
   logic signed [SAMPLE_BITS-1:0] s1_win_ff [LINES];
   logic signed [SAMPLE_BITS-1:0] s1_x_ff;
   logic [ROW_BITS-1:0]           s1_row_ff;
   logic [COL_BITS-1:0]           s1_col_ff;
   logic                          s1_last_ff;

   logic                 accept;
   logic                 emit;
   logic                 last_col;
   logic                 last_row;
   logic [GW_BITS-1:0]   gw;
   logic [GW_BITS-1:0]   gw_minus;
   logic [ROW_BITS-1:0]  gh;

   assign full     = s1_valid_ff && !mid_ready;
   assign accept   = push && !full;
   assign last_col = (col_ff == w_last_ff);
   assign last_row = (row_ff == h_last_ff);
   assign emit     = (dir_ff == DIR_X) ? (col_ff >= COL_BITS'(STENCIL_REACH))
                                       : (row_ff >= ROW_BITS'(STENCIL_REACH));
   assign gw       = csr_wdata[GW_BITS-1:0];
   assign gw_minus = gw - GW_BITS'(1);
   assign gh       = csr_wdata[ROW_BITS-1:0];

   always_comb begin
      dir_in    = dir_ff;
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      priority if (csr_we) begin
         unique case (csr_index)
            CSR_DIRECTION: begin
               dir_in = dir_type'(csr_wdata[0]);
               col_in = '0;
               row_in = '0;
            end
            CSR_GRID_WIDTH: begin
               if (gw == '0) begin
                  w_last_in = '0;
               end else if (gw > GW_BITS'(MAX_WIDTH)) begin
                  w_last_in = COL_BITS'(MAX_WIDTH - 1);
               end else begin
                  w_last_in = gw_minus[COL_BITS-1:0];
               end
               col_in = '0;
               row_in = '0;
            end
            CSR_GRID_HEIGHT: begin
               h_last_in = (gh == '0) ? '0 : gh - ROW_BITS'(1);
               col_in    = '0;
               row_in    = '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end else begin
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = emit;
      end else if (mid_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff      <= DIR_X;
         w_last_ff   <= COL_BITS'(MAX_WIDTH - 1);
         h_last_ff   <= ROW_BITS'(1023);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         dir_ff      <= dir_in;
         w_last_ff   <= w_last_in;
         h_last_ff   <= h_last_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // line store: read all four lines at this column, overwrite the oldest
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int l = 0; l < LINES; l++) begin
            rd_ff[l] <= line_mem[l][col_ff];
            if (row_ff[LANE_BITS-1:0] == LANE_BITS'(l)) begin
               line_mem[l][col_ff] <= req_sample;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int l = 0; l < LINES - 1; l++) begin
            win_ff[l] <= win_ff[l+1];
         end
         win_ff[LINES-1] <= req_sample;
         for (int l = 0; l < LINES; l++) begin
            s1_win_ff[l] <= win_ff[l];
         end
         s1_x_ff    <= req_sample;
         s1_dir_ff  <= dir_ff;
         s1_lane_ff <= row_ff[LANE_BITS-1:0];
         s1_last_ff <= last_row && last_col;
         if (dir_ff == DIR_X) begin
            s1_row_ff <= row_ff;
            s1_col_ff <= col_ff - COL_BITS'(HALF_REACH);
         end else begin
            s1_row_ff <= row_ff - ROW_BITS'(HALF_REACH);
            s1_col_ff <= col_ff;
         end
      end
   end

   always_comb begin
      mid_valid     = s1_valid_ff;
      mid_item.e    = s1_x_ff;
      mid_item.row  = s1_row_ff;
      mid_item.col  = s1_col_ff;
      mid_item.last = s1_last_ff;
      if (s1_dir_ff == DIR_X) begin
         mid_item.a = s1_win_ff[0];
         mid_item.b = s1_win_ff[1];
         mid_item.c = s1_win_ff[2];
         mid_item.d = s1_win_ff[3];
      end else begin
         mid_item.a = rd_ff[s1_lane_ff];
         mid_item.b = rd_ff[s1_lane_ff + LANE_BITS'(1)];
         mid_item.c = rd_ff[s1_lane_ff + LANE_BITS'(2)];
         mid_item.d = rd_ff[s1_lane_ff + LANE_BITS'(3)];
      end
   end

endmodule

FILE: rtl/sds_mid_queue.sv
// Short operand queue between the front end and the arithmetic back end.
// Depends on sds_pkg for the operand item type.
module sds_mid_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  sds_pkg::op_item_type in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output sds_pkg::op_item_type out_item
);
   import sds_pkg::*;

   op_item_type              mem_ff [MID_DEPTH];
   logic [MID_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [MID_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [MID_PTR_BITS:0]    count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign in_ready  = (count_ff != (MID_PTR_BITS+1)'(MID_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + MID_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + MID_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + (MID_PTR_BITS+1)'(do_push) - (MID_PTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

FILE: rtl/sds_back.sv
// Back end: exact stencil sum, divide by 12 with rounding, result queue.
// Credit-based issue keeps the two-stage pipe from overrunning the queue; uses sds_pkg.
module sds_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  sds_pkg::op_item_type              in_item,
   output logic                              empty,
   input  logic                              pop,
   output logic signed [sds_pkg::DER_BITS-1:0] rsp_derivative,
   output logic [sds_pkg::ROW_BITS-1:0]      rsp_out_row,
   output logic [sds_pkg::COL_BITS-1:0]      rsp_out_col,
   output logic                              rsp_frame_last
);
   import sds_pkg::*;

   logic                       b1_valid_ff, b2_valid_ff;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic [ROW_BITS-1:0]        b1_row_ff, b2_row_ff;
   logic [COL_BITS-1:0]        b1_col_ff, b2_col_ff;
   logic                       b1_last_ff, b2_last_ff;
   logic [PROD_BITS-1:0]       prod_ff, prod_in;
   logic                       neg_ff;

   logic signed [SUM_BITS-1:0] ea, eb, ec, ed, ee;
   logic [SUM_BITS-1:0]        abs_sum;
   logic [MAG_BITS-1:0]        rounded;
   logic [QIN_BITS-1:0]        quarter;
   logic [QUO_BITS-1:0]        quo;
   rsp_item_type               oq_wr;

   rsp_item_type               oq_mem_ff [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [OUT_PTR_BITS:0]      count_ff, count_in;
   logic [OUT_PTR_BITS:0]      pending;
   logic                       issue;
   logic                       do_pop;

   assign pending  = count_ff + (OUT_PTR_BITS+1)'(b1_valid_ff)
                   + (OUT_PTR_BITS+1)'(b2_valid_ff);
   assign in_ready = (pending < (OUT_PTR_BITS+1)'(OUT_DEPTH));
   assign issue    = in_valid && in_ready;
   assign empty    = (count_ff == '0);
   assign do_pop   = pop && !empty;

   always_comb begin
      ea     = SUM_BITS'(in_item.a);
      eb     = SUM_BITS'(in_item.b);
      ec     = SUM_BITS'(in_item.c);
      ed     = SUM_BITS'(in_item.d);
      ee     = SUM_BITS'(in_item.e);
      sum_in = ((eb + ed) <<< 4) - (ea + ee) - (ec <<< 5) + (ec <<< 1);
   end

   // round(|s| / 12) = floor(floor((|s| + 6) / 4) / 3), the /3 by reciprocal
   always_comb begin
      abs_sum = sum_ff[SUM_BITS-1] ? -sum_ff : sum_ff;
      rounded = abs_sum[MAG_BITS-1:0] + MAG_BITS'(6);
      quarter = rounded[MAG_BITS-1:2];
      prod_in = PROD_BITS'(quarter) * PROD_BITS'(RECIP3);
   end

   always_comb begin
      quo        = prod_ff[RECIP_SHIFT+QUO_BITS-1:RECIP_SHIFT];
      oq_wr.der  = neg_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      oq_wr.row  = b2_row_ff;
      oq_wr.col  = b2_col_ff;
      oq_wr.last = b2_last_ff;
      count_in   = count_ff + (OUT_PTR_BITS+1)'(b2_valid_ff)
                 - (OUT_PTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         b1_valid_ff <= issue;
         b2_valid_ff <= b1_valid_ff;
         count_ff    <= count_in;
         if (b2_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + OUT_PTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + OUT_PTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff     <= sum_in;
      b1_row_ff  <= in_item.row;
      b1_col_ff  <= in_item.col;
      b1_last_ff <= in_item.last;
      prod_ff    <= prod_in;
      neg_ff     <= sum_ff[SUM_BITS-1];
      b2_row_ff  <= b1_row_ff;
      b2_col_ff  <= b1_col_ff;
      b2_last_ff <= b1_last_ff;
      if (b2_valid_ff) begin
         oq_mem_ff[wr_ptr_ff] <= oq_wr;
      end
   end

   assign rsp_derivative = oq_mem_ff[rd_ptr_ff].der;
   assign rsp_out_row    = oq_mem_ff[rd_ptr_ff].row;
   assign rsp_out_col    = oq_mem_ff[rd_ptr_ff].col;
   assign rsp_frame_last = oq_mem_ff[rd_ptr_ff].last;

endmodule

FILE: rtl/second_derivative_grid_stencil_top.sv
// Top level of the fourth-order second-derivative grid stencil.
// Instantiates sds_front, sds_mid_queue and sds_back; uses sds_pkg.
//
// Samples enter in raster order through a queue-style port: a beat is taken
// when push is high and full is low. Results leave the same way: the oldest
// result sits on the rsp_ ports while empty is low and is taken when pop is
// high. Each result carries its row, column and a frame_last flag.
// The csr_ port writes direction (0), grid_width (1) and grid_height (2);
// a write to any of these restarts the raster position at row 0, column 0.
// Throughput: one sample per cycle while full is low. The result of the
// sample that completes a stencil passes the position/line-store read
// stage, operand queue, sum stage and reciprocal-multiply stage into the
// result queue. z mode keeps four lines of MAX_WIDTH samples in memories
// with one port per line; each sample reads all four and writes one line.
// Reset restores the register defaults, clears the position and empties
// both queues; line-store contents are not cleared and need no sweep.
// When pop stays low the result queue (4 deep) and the operand queue
// (4 deep) fill, then full rises; no result is dropped.
module second_derivative_grid_stencil_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   output logic                                   full,
   input  logic signed [sds_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                   empty,
   input  logic                                   pop,
   output logic signed [sds_pkg::DER_BITS-1:0]    rsp_derivative,
   output logic [sds_pkg::ROW_BITS-1:0]           rsp_out_row,
   output logic [sds_pkg::COL_BITS-1:0]           rsp_out_col,
   output logic                                   rsp_frame_last,
   input  logic                                   csr_we,
   input  logic [sds_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [sds_pkg::CSR_BITS-1:0]           csr_wdata
);
   import sds_pkg::*;

   logic        f_valid, f_ready;
   op_item_type f_item;
   logic        q_valid, q_ready;
   op_item_type q_item;

   sds_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_sample(req_sample),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mid_valid (f_valid),
      .mid_ready (f_ready),
      .mid_item  (f_item)
   );

   sds_mid_queue u_mid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (f_valid),
      .in_ready (f_ready),
      .in_item  (f_item),
      .out_valid(q_valid),
      .out_ready(q_ready),
      .out_item (q_item)
   );

   sds_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (q_valid),
      .in_ready      (q_ready),
      .in_item       (q_item),
      .empty         (empty),
      .pop           (pop),
      .rsp_derivative(rsp_derivative),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_frame_last(rsp_frame_last)
   );

endmodule

FILE: rtl/sds_checker.sv
// Port-level checker for the second-derivative grid stencil, bound to the top.
// Depends on sds_pkg for widths and the result bound.
module sds_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                full,
   input logic                                empty,
   input logic                                pop,
   input logic signed [sds_pkg::DER_BITS-1:0] rsp_derivative,
   input logic [sds_pkg::ROW_BITS-1:0]        rsp_out_row,
   input logic [sds_pkg::COL_BITS-1:0]        rsp_out_col,
   input logic                                rsp_frame_last
);
   import sds_pkg::*;

   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_ready_after_reset: assert property (@(posedge clock) reset |=> !full)
      else $error("input blocked right after reset");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_derivative) && $stable(rsp_out_row)
                            && $stable(rsp_out_col) && $stable(rsp_frame_last)))
      else $error("waiting result changed before pop");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_derivative <= DER_BITS'(DER_LIMIT)
                  && rsp_derivative >= -DER_BITS'(DER_LIMIT)))
      else $error("derivative outside reachable range");

endmodule

bind second_derivative_grid_stencil_top sds_checker u_sds_checker (.*);
